### sv/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("llcp assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("llcp assertion failed");

`endif

### sv/llcp_pkg.sv
// shared constants for the line-line closest points pipeline
`default_nettype none
package llcp_pkg;
    // digits of the first operand in the pipelined multiplier
    localparam int MUL_DIGITS = 6;
    // multiplier stages: magnitude stage, one stage per digit, sign stage
    localparam int MUL_LAT    = MUL_DIGITS + 2;
    // divider stages besides one per quotient bit
    localparam int DIV_EXTRA  = 3;
endpackage
`default_nettype wire

### sv/llcp_delay.sv
// clock-enabled delay line
`default_nettype none
module llcp_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_ce,
    input  wire logic [WIDTH-1:0] i_d,
    output logic      [WIDTH-1:0] o_q
);
    logic [WIDTH-1:0] r_sr [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_sr[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_sr[k] <= r_sr[k-1];
            end
        end
    end

    assign o_q = r_sr[DEPTH-1];
endmodule
`default_nettype wire

### sv/llcp_mul.sv
// pipelined signed multiplier, one digit of the first operand per stage
`default_nettype none
module llcp_mul #(
    parameter int AW = 33,
    parameter int BW = 68
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_ce,
    input  wire logic signed [AW-1:0] i_a,
    input  wire logic signed [BW-1:0] i_b,
    output logic signed [AW+BW-1:0]   o_p
);
    import llcp_pkg::*;

    localparam int ND  = MUL_DIGITS;
    localparam int DGW = (AW + ND - 1) / ND;
    localparam int AP  = DGW * ND;
    localparam int PW  = AW + BW;

    logic [AW-1:0] a_mag;
    logic [BW-1:0] b_mag;
    logic [AP-1:0] r_a   [ND+1];
    logic [BW-1:0] r_b   [ND+1];
    logic          r_neg [ND+1];
    logic [PW-1:0] r_acc [ND+1];
    logic signed [PW-1:0] r_p;

    assign a_mag = i_a[AW-1] ? AW'(-i_a) : AW'(i_a);
    assign b_mag = i_b[BW-1] ? BW'(-i_b) : BW'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_a[0]   <= AP'(a_mag);
            r_b[0]   <= b_mag;
            r_neg[0] <= i_a[AW-1] ^ i_b[BW-1];
            r_acc[0] <= '0;
        end
    end

    for (genvar k = 0; k < ND; k++) begin : g_dig
        logic [DGW+BW-1:0] pp;
        assign pp = r_a[k][k*DGW +: DGW] * r_b[k];
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_a[k+1]   <= r_a[k];
                r_b[k+1]   <= r_b[k];
                r_neg[k+1] <= r_neg[k];
                r_acc[k+1] <= r_acc[k] + (PW'(pp) << (k*DGW));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_p <= r_neg[ND] ? -$signed(r_acc[ND]) : $signed(r_acc[ND]);
        end
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

### sv/llcp_div.sv
// pipelined rounding divider with saturation, one quotient bit per stage
`default_nettype none
module llcp_div #(
    parameter int NW  = 64,
    parameter int DVW = 32,
    parameter int QW  = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_ce,
    input  wire logic signed [NW-1:0] i_n,
    input  wire logic [DVW-1:0]       i_d,
    output logic signed [QW-1:0]      o_q
);
    localparam int MXW = (NW > DVW) ? NW : DVW;
    localparam int RW  = MXW + QW + 2;

    logic [NW-1:0] n_mag;
    logic [RW-1:0] r_m, r_dd;
    logic          r_sg;
    logic [RW-1:0] r_r   [QW+1];
    logic [RW-1:0] r_d   [QW+1];
    logic          r_neg [QW+1];
    logic          r_ovf [QW+1];
    logic [QW-1:0] r_q   [QW+1];
    logic signed [QW-1:0] r_out;
    logic [QW-1:0] qf;

    assign n_mag = i_n[NW-1] ? NW'(-i_n) : NW'(i_n);

    // magnitude doubled plus divisor gives round half away from zero
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_m  <= (RW'(n_mag) << 1) + RW'(i_d);
            r_dd <= RW'(i_d) << 1;
            r_sg <= i_n[NW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_r[0]   <= r_m;
            r_d[0]   <= r_dd;
            r_neg[0] <= r_sg;
            r_ovf[0] <= r_m >= (r_dd << QW);
            r_q[0]   <= '0;
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_bit
        localparam int SH = QW - 1 - j;
        logic          cmp;
        logic [RW-1:0] sub;
        assign sub = r_d[j] << SH;
        assign cmp = r_r[j] >= sub;
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_r[j+1]   <= cmp ? r_r[j] - sub : r_r[j];
                r_d[j+1]   <= r_d[j];
                r_neg[j+1] <= r_neg[j];
                r_ovf[j+1] <= r_ovf[j];
                r_q[j+1]   <= {r_q[j][QW-2:0], cmp};
            end
        end
    end

    assign qf = r_q[QW];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            if (!r_neg[QW]) begin
                if (r_ovf[QW] || qf[QW-1]) r_out <= {1'b0, {(QW-1){1'b1}}};
                else                       r_out <= $signed(qf);
            end else begin
                if (r_ovf[QW] || (qf[QW-1] && (|qf[QW-2:0])))
                    r_out <= {1'b1, {(QW-1){1'b0}}};
                else
                    r_out <= -$signed(qf);
            end
        end
    end

    assign o_q = r_out;
endmodule
`default_nettype wire

### sv/line_line_closest_points.sv
// top level of the line-line closest points pipeline
`default_nettype none
// Shortest segment between two 3D lines. Each transfer on the slave side carries
// two lines (P1P2 and P3P4) in signed fixed point; each transfer on the master
// side carries the closest points Pa, Pb and the parameters mua, mub, rounded
// to nearest (ties away from zero) and saturated to the coordinate range.
// found is low, with all data zero, when a direction is zero or the lines are
// parallel. The pipeline accepts one item every cycle unless the master side
// stalls; its depth is set by three chained wide multiplier rings and the
// bit-per-stage dividers. All stages share one enable, so a stall on the
// master side freezes the pipe.
module line_line_closest_points #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_tvalid,
    output logic      o_s_tready,
    // a_start_x/y/z, a_end_x/y/z, b_start_x/y/z, b_end_x/y/z
    input  wire logic [((12*COORD_WIDTH+7)/8)*8-1:0] i_s_tdata,
    output logic      o_m_tvalid,
    input  wire logic i_m_tready,
    // near_a_x/y/z, near_b_x/y/z, param_a, param_b
    output logic [((8*COORD_WIDTH+7)/8)*8-1:0] o_m_tdata,
    // found
    output logic      o_m_tuser
);
    import llcp_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int DW   = W + 1;
    localparam int PRW  = 2 * DW;
    localparam int DOTW = 2 * DW + 2;
    localparam int DENW = 2 * DOTW + 1;
    localparam int MW   = DOTW + DENW + 1;
    localparam int QW   = DOTW + DENW;
    localparam int NAW  = DW + DENW + 1;
    localparam int NBW  = DW + MW + 1;
    localparam int PAW  = DENW + FRAC_BITS;
    localparam int PBW  = MW + FRAC_BITS;
    localparam int L    = MUL_LAT;
    localparam int DL   = COORD_WIDTH + DIV_EXTRA;
    localparam int NST  = 7 + 3 * L + DL;
    localparam int OTW  = ((8*COORD_WIDTH+7)/8)*8;

    // one enable for the whole pipe: move unless a result waits
    logic ce;
    logic r_vld [NST];
    assign ce         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = ce;
    assign o_m_tvalid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) r_vld[k] <= 1'b0;
        end else if (ce) begin
            r_vld[0] <= i_s_tvalid;
            for (int k = 1; k < NST; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // stage 1: direction and offset vectors
    logic [W-1:0] in_c [12];
    for (genvar k = 0; k < 12; k++) begin : g_in
        assign in_c[k] = i_s_tdata[k*W +: W];
    end

    logic [2:0][W-1:0]  r_p1, r_p3;
    logic [2:0][DW-1:0] r_d21, r_d43, r_d13;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                r_p1[i]  <= in_c[i];
                r_p3[i]  <= in_c[6+i];
                r_d21[i] <= DW'($signed(in_c[3+i])) - DW'($signed(in_c[i]));
                r_d43[i] <= DW'($signed(in_c[9+i])) - DW'($signed(in_c[6+i]));
                r_d13[i] <= DW'($signed(in_c[i])) - DW'($signed(in_c[6+i]));
            end
        end
    end

    // stage 2: coordinate products; dot order is 1343, 4321, 1321, 4343, 2121
    logic signed [PRW-1:0] n_pr [5][3];
    logic signed [PRW-1:0] r_pr [5][3];
    logic                  r_bad2;
    for (genvar i = 0; i < 3; i++) begin : g_pr
        assign n_pr[0][i] = $signed(r_d13[i]) * $signed(r_d43[i]);
        assign n_pr[1][i] = $signed(r_d43[i]) * $signed(r_d21[i]);
        assign n_pr[2][i] = $signed(r_d13[i]) * $signed(r_d21[i]);
        assign n_pr[3][i] = $signed(r_d43[i]) * $signed(r_d43[i]);
        assign n_pr[4][i] = $signed(r_d21[i]) * $signed(r_d21[i]);
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_pr   <= n_pr;
            r_bad2 <= (r_d43 == '0) || (r_d21 == '0);
        end
    end

    // stage 3: dot products
    logic signed [DOTW-1:0] r_dot [5];
    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int k = 0; k < 5; k++) begin
                r_dot[k] <= DOTW'(r_pr[k][0]) + DOTW'(r_pr[k][1]) + DOTW'(r_pr[k][2]);
            end
        end
    end

    // first multiplier ring: denominator and numerator terms
    logic signed [2*DOTW-1:0] g1_dd, g1_ee, g1_n1, g1_n2;
    llcp_mul #(.AW(DOTW), .BW(DOTW)) u_m_dd (.i_clk, .i_ce(ce),
        .i_a(r_dot[4]), .i_b(r_dot[3]), .o_p(g1_dd));
    llcp_mul #(.AW(DOTW), .BW(DOTW)) u_m_ee (.i_clk, .i_ce(ce),
        .i_a(r_dot[1]), .i_b(r_dot[1]), .o_p(g1_ee));
    llcp_mul #(.AW(DOTW), .BW(DOTW)) u_m_n1 (.i_clk, .i_ce(ce),
        .i_a(r_dot[0]), .i_b(r_dot[1]), .o_p(g1_n1));
    llcp_mul #(.AW(DOTW), .BW(DOTW)) u_m_n2 (.i_clk, .i_ce(ce),
        .i_a(r_dot[2]), .i_b(r_dot[3]), .o_p(g1_n2));

    logic bad_g1;
    llcp_delay #(.WIDTH(1), .DEPTH(L+1)) u_dl_bad (.i_clk, .i_ce(ce),
        .i_d(r_bad2), .o_q(bad_g1));

    logic [DOTW-1:0] dot0_g2, dot1_g2, dot3_g2;
    llcp_delay #(.WIDTH(3*DOTW), .DEPTH(L+1)) u_dl_dot (.i_clk, .i_ce(ce),
        .i_d({r_dot[0], r_dot[1], r_dot[3]}), .o_q({dot0_g2, dot1_g2, dot3_g2}));

    logic [2:0][W-1:0]  p1_g2;
    logic [2:0][DW-1:0] d21_g2;
    llcp_delay #(.WIDTH(3*(W+DW)), .DEPTH(3+L)) u_dl_a (.i_clk, .i_ce(ce),
        .i_d({r_p1, r_d21}), .o_q({p1_g2, d21_g2}));

    logic [2:0][W-1:0]  p3_g3;
    logic [2:0][DW-1:0] d43_g3;
    llcp_delay #(.WIDTH(3*(W+DW)), .DEPTH(4+2*L)) u_dl_b (.i_clk, .i_ce(ce),
        .i_d({r_p3, r_d43}), .o_q({p3_g3, d43_g3}));

    // denominator, numerator and the solvability check
    logic signed [DENW-1:0] n_denom, r_denom, r_numer;
    logic                   r_fnd1;
    assign n_denom = DENW'(g1_dd) - DENW'(g1_ee);

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_denom <= n_denom;
            r_numer <= DENW'(g1_n1) - DENW'(g1_n2);
            r_fnd1  <= !bad_g1 && (n_denom != '0) && !n_denom[DENW-1];
        end
    end

    // second multiplier ring: M and Q terms, first line dividends
    logic signed [DOTW+DENW-1:0] g2_ma, g2_mb, g2_q;
    logic signed [W+DENW-1:0]    g2_na1 [3];
    logic signed [DW+DENW-1:0]   g2_na2 [3];
    llcp_mul #(.AW(DOTW), .BW(DENW)) u_m_ma (.i_clk, .i_ce(ce),
        .i_a(dot0_g2), .i_b(r_denom), .o_p(g2_ma));
    llcp_mul #(.AW(DOTW), .BW(DENW)) u_m_mb (.i_clk, .i_ce(ce),
        .i_a(dot1_g2), .i_b(r_numer), .o_p(g2_mb));
    llcp_mul #(.AW(DOTW), .BW(DENW)) u_m_q (.i_clk, .i_ce(ce),
        .i_a(dot3_g2), .i_b(r_denom), .o_p(g2_q));
    for (genvar i = 0; i < 3; i++) begin : g_na
        llcp_mul #(.AW(W), .BW(DENW)) u_m_na1 (.i_clk, .i_ce(ce),
            .i_a(p1_g2[i]), .i_b(r_denom), .o_p(g2_na1[i]));
        llcp_mul #(.AW(DW), .BW(DENW)) u_m_na2 (.i_clk, .i_ce(ce),
            .i_a(d21_g2[i]), .i_b(r_numer), .o_p(g2_na2[i]));
    end

    logic [DENW-1:0] den_s2, num_s2;
    logic            fnd_s2;
    llcp_delay #(.WIDTH(2*DENW+1), .DEPTH(L)) u_dl_g2 (.i_clk, .i_ce(ce),
        .i_d({r_denom, r_numer, r_fnd1}), .o_q({den_s2, num_s2, fnd_s2}));

    logic signed [MW-1:0]  r_m2;
    logic signed [QW-1:0]  r_q2;
    logic [2:0][NAW-1:0]   r_na2;
    logic signed [PAW-1:0] r_pan2;
    logic [DENW-1:0]       r_den2;
    logic                  r_fnd2;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_m2 <= MW'(g2_ma) + MW'(g2_mb);
            r_q2 <= g2_q;
            for (int i = 0; i < 3; i++) begin
                r_na2[i] <= NAW'(g2_na1[i]) + NAW'(g2_na2[i]);
            end
            r_pan2 <= PAW'($signed(num_s2)) << FRAC_BITS;
            r_den2 <= den_s2;
            r_fnd2 <= fnd_s2;
        end
    end

    // third multiplier ring: second line dividends
    logic signed [W+QW-1:0] g3_nb1 [3];
    logic signed [DW+MW-1:0] g3_nb2 [3];
    for (genvar i = 0; i < 3; i++) begin : g_nb
        llcp_mul #(.AW(W), .BW(QW)) u_m_nb1 (.i_clk, .i_ce(ce),
            .i_a(p3_g3[i]), .i_b(r_q2), .o_p(g3_nb1[i]));
        llcp_mul #(.AW(DW), .BW(MW)) u_m_nb2 (.i_clk, .i_ce(ce),
            .i_a(d43_g3[i]), .i_b(r_m2), .o_p(g3_nb2[i]));
    end

    logic [2:0][NAW-1:0] na_s3;
    logic [PAW-1:0]      pan_s3;
    logic [DENW-1:0]     den_s3;
    logic [MW-1:0]       m_s3;
    logic [QW-1:0]       q_s3;
    logic                fnd_s3;
    llcp_delay #(.WIDTH(3*NAW+PAW+DENW+MW+QW+1), .DEPTH(L)) u_dl_g3 (
        .i_clk, .i_ce(ce),
        .i_d({r_na2, r_pan2, r_den2, r_m2, r_q2, r_fnd2}),
        .o_q({na_s3, pan_s3, den_s3, m_s3, q_s3, fnd_s3}));

    logic [2:0][NBW-1:0] r_nb3;
    logic [2:0][NAW-1:0] r_na3;
    logic [PBW-1:0]      r_pbn3;
    logic [PAW-1:0]      r_pan3;
    logic [DENW-1:0]     r_den3;
    logic [QW-1:0]       r_q3;
    logic                r_fnd3;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                r_nb3[i] <= NBW'(g3_nb1[i]) + NBW'(g3_nb2[i]);
            end
            r_na3  <= na_s3;
            r_pbn3 <= PBW'($signed(m_s3)) << FRAC_BITS;
            r_pan3 <= pan_s3;
            r_den3 <= den_s3;
            r_q3   <= q_s3;
            r_fnd3 <= fnd_s3;
        end
    end

    // dividers: rounded, saturated quotients
    logic signed [W-1:0] q_na [3];
    logic signed [W-1:0] q_nb [3];
    logic signed [W-1:0] q_pa, q_pb;
    for (genvar i = 0; i < 3; i++) begin : g_div
        llcp_div #(.NW(NAW), .DVW(DENW), .QW(W)) u_d_na (.i_clk, .i_ce(ce),
            .i_n(r_na3[i]), .i_d(r_den3), .o_q(q_na[i]));
        llcp_div #(.NW(NBW), .DVW(QW), .QW(W)) u_d_nb (.i_clk, .i_ce(ce),
            .i_n(r_nb3[i]), .i_d(r_q3), .o_q(q_nb[i]));
    end
    llcp_div #(.NW(PAW), .DVW(DENW), .QW(W)) u_d_pa (.i_clk, .i_ce(ce),
        .i_n(r_pan3), .i_d(r_den3), .o_q(q_pa));
    llcp_div #(.NW(PBW), .DVW(QW), .QW(W)) u_d_pb (.i_clk, .i_ce(ce),
        .i_n(r_pbn3), .i_d(r_q3), .o_q(q_pb));

    logic fnd_dv;
    llcp_delay #(.WIDTH(1), .DEPTH(DL)) u_dl_fnd (.i_clk, .i_ce(ce),
        .i_d(r_fnd3), .o_q(fnd_dv));

    // output register: degenerate items carry all-zero data
    logic [OTW-1:0] r_tdata;
    logic           r_tuser;
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_tuser <= fnd_dv;
            if (fnd_dv) begin
                r_tdata <= OTW'({q_pb, q_pa, q_nb[2], q_nb[1], q_nb[0],
                                 q_na[2], q_na[1], q_na[0]});
            end else begin
                r_tdata <= '0;
            end
        end
    end

    assign o_m_tdata = r_tdata;
    assign o_m_tuser = r_tuser;

`include "assert_macros.svh"

    `ASSERT_IMPL(a_nofound_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser, o_m_tdata == '0)
    `ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !ce, r_vld[0] == $past(r_vld[0]))
    `ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_vld[0])
endmodule
`default_nettype wire
